FILE: hdl/setsrch_pkg.sv
// Package for the scope edge-trigger search core: codes, types and defaults.
// No dependencies; used by the interfaces, the core, the checker and the testbench.
package setsrch_pkg;

   localparam int STORE_DEPTH_DEFAULT = 2048;
   localparam int BACKOFF_DEFAULT     = 64;

   localparam int SAMPLE_W = 12;
   localparam int POS_W    = 11;

   localparam logic [SAMPLE_W-1:0] EDGE_LEVEL_RESET  = 12'd2048;
   localparam logic                EDGE_RISING_RESET = 1'b1;

   typedef enum logic [0:0] {
      OP_APPEND = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      CSR_EDGE_LEVEL  = 1'b0,
      CSR_EDGE_RISING = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIRST,
      ST_STEP,
      ST_FINISH
   } state_type;

endpackage

FILE: hdl/setsrch_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on setsrch_pkg for the field widths.
interface setsrch_req_if
   import setsrch_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                operation;
   logic [SAMPLE_W-1:0] sample_value;

   modport source (output valid, output operation, output sample_value, input ready);
   modport sink   (input valid, input operation, input sample_value, output ready);
endinterface

interface setsrch_rsp_if
   import setsrch_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] found_position;
   logic             found_flag;

   modport source (output valid, output found_position, output found_flag, input ready);
   modport sink   (input valid, input found_position, input found_flag, output ready);
endinterface

FILE: hdl/setsrch_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module setsrch_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/scope_edge_trigger_search_core.sv
// Append: one transfer per cycle, no response. Search: the first read is issued as the request is taken, then
// one sample read per cycle from the single RAM port; once a crossing is found or the step limit is
// reached, the response register is loaded as soon as the previous response has been taken.
// Requests are not taken while a search runs. Synchronous active-high reset; entries never
// written read as zero through the write pointer and wrap flag, so no clearing pass is needed.
module scope_edge_trigger_search_core
   import setsrch_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT,
   parameter int BACKOFF     = BACKOFF_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   setsrch_req_if.sink         req_ch,
   setsrch_rsp_if.source       rsp_ch,
   input  logic                csr_we,
   input  csr_index_type       csr_index,
   input  logic [SAMPLE_W-1:0] csr_wdata
);

   localparam int IDX_W  = $clog2(STORE_DEPTH);
   localparam int STEP_W = $clog2(STORE_DEPTH / 2);
   localparam logic [IDX_W-1:0]  BACK_OFS  = IDX_W'((BACKOFF + 1) % STORE_DEPTH);
   localparam logic [IDX_W-1:0]  WRAP_ADD  = IDX_W'(STORE_DEPTH - ((BACKOFF + 1) % STORE_DEPTH));
   localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(STORE_DEPTH - 1);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STORE_DEPTH / 2 - 1);

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    wp_ff, wp_in;
   logic                wrapped_ff, wrapped_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [IDX_W-1:0]    start_ff, start_in;
   logic [SAMPLE_W-1:0] newer_ff, newer_in;
   logic [STEP_W-1:0]   steps_ff, steps_in;
   logic                ok_ff, ok_in;
   logic [IDX_W-1:0]    res_pos_ff, res_pos_in;
   logic                res_flag_ff, res_flag_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic                rsp_flag_ff, rsp_flag_in;
   logic [SAMPLE_W-1:0] level_ff;
   logic                rising_ff;

   logic [IDX_W-1:0]       ram_addr;
   logic                   ram_we;
   logic [SAMPLE_W-1:0]    ram_rdata;
   logic [SAMPLE_W-1:0]    rd_sample;
   logic [IDX_W-1:0]       start_calc;
   logic [IDX_W-1:0]       cur_dec;
   logic                   hit;
   logic                   req_take;
   logic [IDX_W+POS_W-1:0] pos_ext;

   setsrch_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we),
      .wdata (req_ch.sample_value),
      .rdata (ram_rdata)
   );

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign req_take              = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.found_position = rsp_pos_ff;
   assign rsp_ch.found_flag     = rsp_flag_ff;

   assign start_calc = (wp_ff >= BACK_OFS) ? (wp_ff - BACK_OFS) : (wp_ff + WRAP_ADD);
   assign cur_dec    = (cur_ff == '0) ? IDX_LAST : (cur_ff - 1'b1);
   assign rd_sample  = ok_ff ? ram_rdata : '0;
   assign hit        = rising_ff ? ((rd_sample < level_ff) && (newer_ff > level_ff))
                                 : ((rd_sample > level_ff) && (newer_ff < level_ff));
   assign pos_ext    = {{POS_W{1'b0}}, res_pos_ff};
   assign ok_in      = wrapped_ff || (ram_addr < wp_ff);

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      wrapped_in   = wrapped_ff;
      cur_in       = cur_ff;
      start_in     = start_ff;
      newer_in     = newer_ff;
      steps_in     = steps_ff;
      res_pos_in   = res_pos_ff;
      res_flag_in  = res_flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_flag_in  = rsp_flag_ff;
      ram_addr     = cur_dec;
      ram_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ram_addr = start_calc;
            if (req_take) begin
               if (req_ch.operation == OP_SEARCH) begin
                  cur_in   = start_calc;
                  start_in = start_calc;
                  state_in = ST_FIRST;
               end else begin
                  ram_addr = wp_ff;
                  ram_we   = 1'b1;
                  if (wp_ff == IDX_LAST) begin
                     wp_in      = '0;
                     wrapped_in = 1'b1;
                  end else begin
                     wp_in = wp_ff + 1'b1;
                  end
               end
            end
         end
         ST_FIRST: begin
            newer_in = rd_sample;
            cur_in   = cur_dec;
            steps_in = STEP_W'(1);
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (hit) begin
               res_pos_in  = cur_ff;
               res_flag_in = 1'b1;
               state_in    = ST_FINISH;
            end else if (steps_ff == STEP_LAST) begin
               res_pos_in  = start_ff;
               res_flag_in = 1'b0;
               state_in    = ST_FINISH;
            end else begin
               newer_in = rd_sample;
               cur_in   = cur_dec;
               steps_in = steps_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_ext[POS_W-1:0];
               rsp_flag_in  = res_flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         level_ff     <= EDGE_LEVEL_RESET;
         rising_ff    <= EDGE_RISING_RESET;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         wrapped_ff   <= wrapped_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_EDGE_LEVEL:  level_ff  <= csr_wdata;
               CSR_EDGE_RISING: rising_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      start_ff    <= start_in;
      newer_ff    <= newer_in;
      steps_ff    <= steps_in;
      ok_ff       <= ok_in;
      res_pos_ff  <= res_pos_in;
      res_flag_ff <= res_flag_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_flag_ff <= rsp_flag_in;
   end

endmodule

FILE: hdl/setsrch_checker.sv
// Port-level checks for scope_edge_trigger_search_core, bound to the top level.
// Depends on setsrch_pkg for the operation codes and widths.
module setsrch_checker
   import setsrch_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_operation,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [POS_W-1:0] rsp_found_position,
   input logic             rsp_found_flag
);

   // a search holds off the request side in the cycle after it is taken
   a_search_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_operation == OP_SEARCH)) |=> !req_ready)
      else $error("request taken right after a search transfer");

   // an append never produces a response by itself
   a_append_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_operation == OP_APPEND) && !rsp_valid) |=> !rsp_valid)
      else $error("response appeared after an append");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_found_position) && $stable(rsp_found_flag)))
      else $error("stalled response changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("not idle after reset");

endmodule

bind scope_edge_trigger_search_core setsrch_checker u_setsrch_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .req_operation      (req_ch.operation),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_found_position (rsp_ch.found_position),
   .rsp_found_flag     (rsp_ch.found_flag)
);

FILE: tb/sv/scope_edge_trigger_search_core_tb.sv
`timescale 1ns / 1ps
// Testbench for scope_edge_trigger_search_core: sample appends and edge searches, checked
// against an in-bench trigger predictor. Depends on setsrch_pkg and the setsrch channel interfaces.
module scope_edge_trigger_search_core_tb;
   import setsrch_pkg::*;

   localparam int DEPTH      = STORE_DEPTH_DEFAULT;
   localparam int BACKOFF    = BACKOFF_DEFAULT;
   localparam int STALL_MAX  = 5000;
   localparam int PHASE_SIZE = 190;

   typedef struct packed {
      logic [POS_W-1:0] found_position;
      logic             found_flag;
   } trigger_result_type;

   class trigger_scoreboard;
      logic [SAMPLE_W-1:0] samples [DEPTH];
      int unsigned         next_slot;
      logic [SAMPLE_W-1:0] level;
      logic                rising;
      trigger_result_type  results_due[$];
      int                  errors;
      int                  appends;
      int                  searches;
      int                  hits;
      int                  checked;

      function new();
         foreach (samples[i]) samples[i] = '0;
         next_slot = 0;
         level     = EDGE_LEVEL_RESET;
         rising    = EDGE_RISING_RESET;
         errors    = 0;
         appends   = 0;
         searches  = 0;
         hits      = 0;
         checked   = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [SAMPLE_W-1:0] data);
         case (idx)
            CSR_EDGE_LEVEL:  level = data;
            CSR_EDGE_RISING: rising = data[0];
            default: ;
         endcase
      endfunction

      // walk back from the newest sample minus the back-off, older/newer pairs in time order
      function trigger_result_type locate_crossing();
         trigger_result_type  res;
         int unsigned         first;
         int unsigned         idx;
         logic [SAMPLE_W-1:0] newer;
         logic [SAMPLE_W-1:0] older;
         first = (next_slot + DEPTH - 1 - BACKOFF) % DEPTH;
         idx = first;
         res.found_flag = 1'b0;
         res.found_position = POS_W'(first);
         for (int step = 1; step < DEPTH / 2; step++) begin
            newer = samples[idx];
            idx = (idx + DEPTH - 1) % DEPTH;
            older = samples[idx];
            if (rising ? (older < level && newer > level) : (older > level && newer < level)) begin
               res.found_flag = 1'b1;
               res.found_position = POS_W'(idx);
               break;
            end
         end
         return res;
      endfunction

      function void note_request(op_type op, logic [SAMPLE_W-1:0] value);
         if (op == OP_APPEND) begin
            samples[next_slot] = value;
            next_slot = (next_slot + 1) % DEPTH;
            appends++;
         end else begin
            results_due.push_back(locate_crossing());
            searches++;
         end
      endfunction

      function void check_response(logic [POS_W-1:0] pos, logic flag);
         trigger_result_type want;
         checked++;
         if (results_due.size() == 0) begin
            $error("response transfer with no search outstanding: pos %0d flag %0d", pos, flag);
            errors++;
            return;
         end
         want = results_due.pop_front();
         if (want.found_flag) hits++;
         if (pos !== want.found_position) begin
            $error("found_position: expected %0d, actual %0d", want.found_position, pos);
            errors++;
         end
         if (flag !== want.found_flag) begin
            $error("found_flag: expected %0d, actual %0d", want.found_flag, flag);
            errors++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_we;
   csr_index_type       csr_index;
   logic [SAMPLE_W-1:0] csr_wdata;
   logic                calm;
   int                  quiet_cycles;

   trigger_scoreboard model = new();

   setsrch_req_if req_ch ();
   setsrch_rsp_if rsp_ch ();

   scope_edge_trigger_search_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (calm) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= 20);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         model.note_request(op_type'(req_ch.operation), req_ch.sample_value);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         model.check_response(rsp_ch.found_position, rsp_ch.found_flag);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_MAX) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic [SAMPLE_W-1:0] clamp_sample(int v);
      if (v < 0) return '0;
      if (v > 4095) return '1;
      return SAMPLE_W'(v);
   endfunction

   task automatic send_item(op_type op, logic [SAMPLE_W-1:0] value);
      int gap;
      if (!calm && $urandom_range(0, 99) < 20) begin
         gap = $urandom_range(1, 4);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.operation    <= op;
      req_ch.sample_value <= value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_search();
      send_item(OP_SEARCH, SAMPLE_W'($urandom_range(0, 4095)));
   endtask

   // drop valid and hold off until every search has answered
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (model.results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [SAMPLE_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      model.set_register(idx, data);
   endtask

   task automatic apply_setting(logic [SAMPLE_W-1:0] level, logic rising);
      settle();
      write_csr(CSR_EDGE_LEVEL, level);
      write_csr(CSR_EDGE_RISING, {{(SAMPLE_W-1){1'b0}}, rising});
   endtask

   // a run of appends shaped around the current level so crossings turn up
   task automatic send_burst();
      int                  kind;
      int                  len;
      int                  span;
      int                  half;
      int                  offset;
      int                  lvl;
      logic [SAMPLE_W-1:0] flat;
      logic [SAMPLE_W-1:0] value;
      kind   = $urandom_range(0, 3);
      len    = $urandom_range(4, 40);
      span   = $urandom_range(0, 40);
      half   = $urandom_range(1, 6);
      offset = $urandom_range(0, 11);
      lvl    = int'(model.level);
      case ($urandom_range(0, 3))
         0: flat = model.level;
         1: flat = clamp_sample(lvl - 1);
         2: flat = clamp_sample(lvl + 1);
         default: flat = SAMPLE_W'($urandom_range(0, 4095));
      endcase
      for (int k = 0; k < len; k++) begin
         case (kind)
            0: value = SAMPLE_W'($urandom_range(0, 4095));
            1: value = (((k + offset) / half) % 2) ? clamp_sample(lvl + span)
                                                   : clamp_sample(lvl - span);
            2: value = clamp_sample(lvl + $urandom_range(0, 4) - 2);
            default: value = flat;
         endcase
         send_item(OP_APPEND, value);
      end
   endtask

   initial begin
      int                  levels [8];
      bit                  risings [8];
      int                  target;
      int                  pick;
      logic [SAMPLE_W-1:0] lvl;
      levels  = '{2048, 2048, 0, 4095, -1, -1, 1, 4094};
      risings = '{1, 0, 1, 0, 1, 0, 0, 1};
      reset               <= 1'b1;
      calm                <= 1'b0;
      csr_we              <= 1'b0;
      csr_index           <= CSR_EDGE_LEVEL;
      csr_wdata           <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.operation    <= OP_APPEND;
      req_ch.sample_value <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty store, start point wrap, extreme and on-level samples, extreme levels
      send_search();
      send_item(OP_APPEND, 12'd0);
      send_item(OP_APPEND, 12'd4095);
      send_item(OP_APPEND, 12'd2048);
      send_item(OP_APPEND, 12'd2047);
      send_item(OP_APPEND, 12'd2049);
      send_item(OP_APPEND, 12'd1);
      send_item(OP_APPEND, 12'd4094);
      send_search();
      apply_setting(12'd2048, 1'b0);
      send_search();
      apply_setting(12'd0, 1'b0);
      send_search();
      apply_setting(12'd4095, 1'b1);
      send_search();

      for (int p = 0; p < 8; p++) begin
         lvl = (levels[p] < 0) ? SAMPLE_W'($urandom_range(0, 4095)) : SAMPLE_W'(levels[p]);
         apply_setting(lvl, risings[p]);
         calm <= (p == 3);
         target = model.appends + model.searches + PHASE_SIZE;
         while (model.appends + model.searches < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               send_burst();
               if ($urandom_range(0, 9) < 7) send_search();
            end else if (pick < 85) begin
               send_item(OP_APPEND, SAMPLE_W'($urandom_range(0, 4095)));
            end else begin
               send_search();
            end
         end
      end

      settle();
      repeat (8) @(posedge clock);
      $display("run covered %0d sample appends and %0d trigger searches, %0d of them hits,",
               model.appends, model.searches, model.hits);
      $display("over 12 edge level and polarity settings including both level extremes");
      if (model.errors == 0 && model.results_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
